// ----- hdl/gic_pkg.sv -----
// shared types and constants for the gamepad input conditioner
package gic_pkg;

    localparam int CFG_W = 12;
    localparam int REG_IDX_W = 3;

    typedef logic [CFG_W-1:0] t_cfg_val;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    typedef logic [1:0] t_flick;

    localparam t_reg_idx REG_DEADZONE = 3'd0;
    localparam t_reg_idx REG_AXIS_ARM = 3'd1;
    localparam t_reg_idx REG_AXIS_REL = 3'd2;
    localparam t_reg_idx REG_TRIG_ARM = 3'd3;
    localparam t_reg_idx REG_TRIG_REL = 3'd4;

    localparam t_cfg_val RST_DEADZONE = 12'd410;
    localparam t_cfg_val RST_AXIS_ARM = 12'd1228;
    localparam t_cfg_val RST_AXIS_REL = 12'd819;
    localparam t_cfg_val RST_TRIG_ARM = 12'd2866;
    localparam t_cfg_val RST_TRIG_REL = 12'd1229;

    localparam t_flick FLICK_NONE = 2'd0;
    localparam t_flick FLICK_POS  = 2'd1;
    localparam t_flick FLICK_NEG  = 2'd2;

    typedef struct packed {
        t_cfg_val dz_limit;
        t_cfg_val arm_level;
        t_cfg_val rel_level;
    } t_axis_cfg;

endpackage

// ----- hdl/gic_axis.sv -----
// one stick axis: scaling, deadzone and flick detection
module gic_axis #(
    parameter int ADC_BITS = 12,
    parameter bit NEGATE = 1'b0
) (
    input  logic [ADC_BITS-1:0]  i_code,
    input  gic_pkg::t_axis_cfg   i_cfg,
    input  logic [1:0]           i_flags,
    input  gic_pkg::t_flick      i_prev_flick,
    output logic signed [ADC_BITS:0] o_value,
    output gic_pkg::t_flick      o_flick,
    output logic [1:0]           o_flags
);
    import gic_pkg::*;

    localparam int CW = (ADC_BITS + 2 > CFG_W + 1) ? ADC_BITS + 2 : CFG_W + 1;
    localparam int FS = (2 ** ADC_BITS) - 1;

    logic signed [CW-1:0] s_raw;
    logic signed [CW-1:0] s_sgn;
    logic signed [CW-1:0] mag;
    logic signed [CW-1:0] s_val;
    logic signed [CW-1:0] dz;
    logic signed [CW-1:0] arm;
    logic signed [CW-1:0] rel;

    assign dz  = $signed(CW'(i_cfg.dz_limit));
    assign arm = $signed(CW'(i_cfg.arm_level));
    assign rel = $signed(CW'(i_cfg.rel_level));

    assign s_raw = $signed(CW'({i_code, 1'b0})) - $signed(CW'(FS));
    assign s_sgn = NEGATE ? -s_raw : s_raw;
    assign mag   = s_sgn[CW-1] ? -s_sgn : s_sgn;
    assign s_val = (mag < dz) ? '0 : s_sgn;
    assign o_value = $signed(s_val[ADC_BITS:0]);

    always_comb begin
        logic [1:0] flags;
        flags = (i_prev_flick != FLICK_NONE) ? 2'b00 : i_flags;
        if (s_val > arm) begin
            flags[0] = 1'b1;
        end
        if (s_val < -arm) begin
            flags[1] = 1'b1;
        end
        o_flick = FLICK_NONE;
        if (flags[1] && s_val > -rel) begin
            o_flick = FLICK_NEG;
        end else if (flags[0] && s_val < rel) begin
            o_flick = FLICK_POS;
        end
        o_flags = flags;
    end

endmodule

// ----- hdl/gamepad_input_conditioner.sv -----
// top level of the gamepad input conditioner
// Takes one beat of stick, trigger and button samples per clock when not stalled and
// returns one result beat per input beat, in order. A beat is held in the input register
// and then moves to the result register, from which it is offered; with the result side
// ready the block sustains one beat every cycle. Stick values are 2*code minus full scale
// (left Y and right X negated), zeroed inside the deadzone; flick codes and button edges
// depend on the previous beat.
// Registers are written through the config channel (always ready) and should only change
// while no beat is in flight.
module gamepad_input_conditioner #(
    parameter int BUTTON_COUNT = 14,
    parameter int ADC_BITS = 12,
    localparam int IN_W = 6 * ADC_BITS + BUTTON_COUNT,
    localparam int IN_PW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = 4 * (ADC_BITS + 1) + 2 * ADC_BITS + 2 * BUTTON_COUNT + 10,
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // lx, ly, rx, ry, left trigger, right trigger codes, button levels, zero pad
    input  logic [IN_PW-1:0]        i_s_tdata,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // lx, ly, rx, ry values, left level, right level, rising, falling,
    // axis flicks, trigger flicks, zero pad
    output logic [OUT_PW-1:0]       o_m_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  gic_pkg::t_reg_idx       i_cfg_index,
    input  gic_pkg::t_cfg_val       i_cfg_data
);
    import gic_pkg::*;

    localparam int AV = ADC_BITS + 1;
    localparam int TW = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
    localparam int O_LT = 4 * AV;
    localparam int O_RT = O_LT + ADC_BITS;
    localparam int O_RISE = O_RT + ADC_BITS;
    localparam int O_FALL = O_RISE + BUTTON_COUNT;
    localparam int O_AFL = O_FALL + BUTTON_COUNT;
    localparam int O_TFL = O_AFL + 8;

    t_cfg_val r_dz, r_axis_arm, r_axis_rel, r_trig_arm, r_trig_rel;

    logic                    r_in_valid;
    logic [IN_W-1:0]         r_in_data;
    logic                    r_out_valid;
    logic [OUT_PW-1:0]       r_out_data;

    logic [BUTTON_COUNT-1:0] r_prev_btn;
    logic [7:0]              r_axis_flags;
    logic [1:0]              r_trig_flags;
    logic [7:0]              r_prev_afl;
    logic [1:0]              r_prev_tfl;

    logic                    out_free;
    logic                    advance;
    t_axis_cfg               axis_cfg;
    logic signed [AV-1:0]    ax_val [4];
    logic [7:0]              n_axis_flags;
    logic [7:0]              n_afl;
    logic [1:0]              n_trig_flags;
    logic [1:0]              n_tfl;
    logic [ADC_BITS-1:0]     trig_lvl [2];
    logic [BUTTON_COUNT-1:0] btn;
    logic [OUT_PW-1:0]       n_out_data;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign advance     = r_in_valid && out_free;
    assign o_s_tready  = !r_in_valid || out_free;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign axis_cfg = '{dz_limit: r_dz, arm_level: r_axis_arm, rel_level: r_axis_rel};

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz       <= RST_DEADZONE;
            r_axis_arm <= RST_AXIS_ARM;
            r_axis_rel <= RST_AXIS_REL;
            r_trig_arm <= RST_TRIG_ARM;
            r_trig_rel <= RST_TRIG_REL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEADZONE: r_dz       <= i_cfg_data;
                REG_AXIS_ARM: r_axis_arm <= i_cfg_data;
                REG_AXIS_REL: r_axis_rel <= i_cfg_data;
                REG_TRIG_ARM: r_trig_arm <= i_cfg_data;
                REG_TRIG_REL: r_trig_rel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_axis
            gic_axis #(
                .ADC_BITS (ADC_BITS),
                .NEGATE   ((k == 1) || (k == 2))
            ) u_axis (
                .i_code       (r_in_data[k*ADC_BITS +: ADC_BITS]),
                .i_cfg        (axis_cfg),
                .i_flags      (r_axis_flags[2*k +: 2]),
                .i_prev_flick (r_prev_afl[2*k +: 2]),
                .o_value      (ax_val[k]),
                .o_flick      (n_afl[2*k +: 2]),
                .o_flags      (n_axis_flags[2*k +: 2])
            );
        end
    endgenerate

    assign trig_lvl[0] = r_in_data[4*ADC_BITS +: ADC_BITS];
    assign trig_lvl[1] = ~r_in_data[5*ADC_BITS +: ADC_BITS];
    assign btn         = r_in_data[6*ADC_BITS +: BUTTON_COUNT];

    // trigger flick detectors
    always_comb begin
        logic armed;
        for (int t = 0; t < 2; t++) begin
            armed = r_prev_tfl[t] ? 1'b0 : r_trig_flags[t];
            if (TW'(trig_lvl[t]) > TW'(r_trig_arm)) begin
                armed = 1'b1;
            end
            n_trig_flags[t] = armed;
            n_tfl[t] = armed && (TW'(trig_lvl[t]) < TW'(r_trig_rel));
        end
    end

    always_comb begin
        n_out_data = '0;
        for (int a = 0; a < 4; a++) begin
            n_out_data[a*AV +: AV] = ax_val[a];
        end
        n_out_data[O_LT +: ADC_BITS]     = trig_lvl[0];
        n_out_data[O_RT +: ADC_BITS]     = trig_lvl[1];
        n_out_data[O_RISE +: BUTTON_COUNT] = btn & ~r_prev_btn;
        n_out_data[O_FALL +: BUTTON_COUNT] = ~btn & r_prev_btn;
        n_out_data[O_AFL +: 8]           = n_afl;
        n_out_data[O_TFL +: 2]           = n_tfl;
    end

    // input register, result register and tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_btn   <= '0;
            r_axis_flags <= '0;
            r_trig_flags <= '0;
            r_prev_afl   <= '0;
            r_prev_tfl   <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_prev_btn   <= btn;
                r_axis_flags <= n_axis_flags;
                r_trig_flags <= n_trig_flags;
                r_prev_afl   <= n_afl;
                r_prev_tfl   <= n_tfl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata[IN_W-1:0];
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input beat lost while result side stalled");

    a_flick_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_prev_afl == r_out_data[O_AFL +: 8]
                         && r_prev_tfl == r_out_data[O_TFL +: 2]))
        else $error("flick history out of step with result register");

    a_flick_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_prev_afl[1:0] != 2'b11 && r_prev_afl[3:2] != 2'b11
                         && r_prev_afl[5:4] != 2'b11 && r_prev_afl[7:6] != 2'b11))
        else $error("axis flick both directions at once");

    a_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[O_RISE +: BUTTON_COUNT]
                          & r_out_data[O_FALL +: BUTTON_COUNT]) == '0))
        else $error("button both rising and falling");

endmodule
